// ===== sv/pofl_pkg.sv =====
package pofl_pkg;

  // sizing of the allocator
  localparam int NUM_CLASSES    = 12;
  localparam int ARENA_GRANULES = 4096;
  localparam int GRANULE_BYTES  = 16;
  localparam int HEADER_BYTES   = 8;

  // field widths of the requests and results
  localparam int SIZE_W   = 24;
  localparam int ADDR_W   = 16;
  localparam int CLASS_W  = 4;
  localparam int STATUS_W = 3;

  // derived widths
  localparam int GRAN_W = $clog2(ARENA_GRANULES);
  localparam int PTR_W  = GRAN_W + 1;
  localparam int OFFS_W = $clog2(GRANULE_BYTES);
  localparam int K_W    = $clog2(NUM_CLASSES + 1);
  localparam int CI_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int NEED_W = SIZE_W + 1;
  localparam int SPAN_W = ((PTR_W > NUM_CLASSES) ? PTR_W : NUM_CLASSES) + 1;

  // head value of an empty list
  localparam logic [PTR_W-1:0] EMPTY_MARK = PTR_W'(ARENA_GRANULES);

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FROM_LIST  = 3'd0,
    ST_FROM_ARENA = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_ARENA_FULL = 3'd3,
    ST_BAD_SIZE   = 3'd4,
    ST_FREED      = 3'd5,
    ST_NULL       = 3'd6
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [SIZE_W-1:0]  request_size;
    logic [ADDR_W-1:0]  block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  user_address;
    logic [CLASS_W-1:0] size_class;
    status_t            status;
  } rsp_t;

  // decoded request kinds
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_BAD_SIZE,
    OP_TOO_LARGE,
    OP_NULL
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [K_W-1:0]      cls;
    logic [GRAN_W-1:0]   granule;
  } op_t;

  // write port of the link and tag memories
  typedef struct packed {
    logic                link_we;
    logic                tag_we;
    logic [GRAN_W-1:0]   addr;
    logic [PTR_W-1:0]    link;
    logic [CI_W-1:0]     tag;
  } mem_wr_t;

endpackage

// ===== sv/pofl_decode.sv =====
module pofl_decode import pofl_pkg::*; (
  input  req_t req,
  output op_t  op
);

  logic [NEED_W-1:0]        need;
  logic [K_W-1:0]           cnt;
  logic [ADDR_W-OFFS_W-1:0] gfull;
  logic                     in_arena;

  // class count: number of block sizes still below size plus header
  always_comb begin
    need = {1'b0, req.request_size} + NEED_W'(HEADER_BYTES);
    cnt  = '0;
    for (int j = 0; j < NUM_CLASSES; j++) begin
      if ((NEED_W'(GRANULE_BYTES) << j) < need) begin
        cnt = cnt + K_W'(1);
      end
    end
  end

  // granule of a freed user address, header stripped
  assign gfull    = (ADDR_W-OFFS_W)'((req.block_address - ADDR_W'(HEADER_BYTES)) >> OFFS_W);
  assign in_arena = (32'(gfull) < 32'(ARENA_GRANULES));

  // request kind
  always_comb begin
    op.cls     = cnt;
    op.granule = GRAN_W'(gfull);
    if (req.mode == MODE_ALLOC) begin
      if (req.request_size == '0) begin
        op.kind = OP_BAD_SIZE;
      end else if (cnt == K_W'(NUM_CLASSES)) begin
        op.kind = OP_TOO_LARGE;
      end else begin
        op.kind = OP_ALLOC;
      end
    end else begin
      if (req.block_address == '0 || !in_arena) begin
        op.kind = OP_NULL;
      end else begin
        op.kind = OP_FREE;
      end
    end
  end

endmodule

// ===== sv/pofl_store.sv =====
module pofl_store import pofl_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [GRAN_W-1:0] rd_addr,
  output logic [PTR_W-1:0]  link_rd,
  output logic [CI_W-1:0]   tag_rd,
  input  mem_wr_t           wr
);

  logic [PTR_W-1:0] link_mem [ARENA_GRANULES];
  logic [CI_W-1:0]  tag_mem  [ARENA_GRANULES];

  // registered read of link and tag at one granule
  always_ff @(posedge clk) begin
    if (rd_en) begin
      link_rd <= link_mem[rd_addr];
      tag_rd  <= tag_mem[rd_addr];
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr.link_we) begin
      link_mem[wr.addr] <= wr.link;
    end
    if (wr.tag_we) begin
      tag_mem[wr.addr] <= wr.tag;
    end
  end

endmodule

// ===== sv/power_of_two_free_list_allocator.sv =====
// channel  | dir | handshake              | payload
// ---------+-----+------------------------+-------------------------------
// in       | in  | in_valid / in_ready    | req_t: mode, size, address
// out      | out | out_valid / out_ready  | rsp_t: address, class, status
//
// each request first reads the head register and the link and tag memories
// (S_IDLE), then updates the lists and loads the result (S_EXEC); the
// registered memory read is why these are separate steps.
// reset empties every class list and clears the bump pointer; no memory sweep.
// a waiting result does not block the next request; a request whose result
// finds the output register still full holds until it is taken.
module power_of_two_free_list_allocator import pofl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t            state;
  op_t               op;
  op_t               dec_op;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  bump;
  logic [PTR_W-1:0]  bump_next;
  logic [PTR_W-1:0]  heads [NUM_CLASSES];

  logic [CI_W-1:0]   head_idx;
  logic [PTR_W-1:0]  head_rd;
  logic              rd_en;
  logic [GRAN_W-1:0] rd_addr;
  logic [PTR_W-1:0]  link_rd;
  logic [CI_W-1:0]   tag_rd;
  mem_wr_t           wr;

  logic              exec_go;
  logic              carve;
  logic [SPAN_W-1:0] span;
  logic              full;
  logic              head_we;
  logic [CI_W-1:0]   head_wr_idx;
  logic [PTR_W-1:0]  head_wr_val;
  rsp_t              rsp_next;

  pofl_decode u_decode (
    .req (in_req),
    .op  (dec_op)
  );

  pofl_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .link_rd (link_rd),
    .tag_rd  (tag_rd),
    .wr      (wr)
  );

  // one head read a cycle: class of new request, or tag of block being freed
  always_comb begin
    if (state == S_IDLE) begin
      head_idx = (dec_op.kind == OP_ALLOC) ? dec_op.cls[CI_W-1:0] : '0;
    end else begin
      head_idx = (32'(tag_rd) < 32'(NUM_CLASSES)) ? tag_rd : '0;
    end
  end
  assign head_rd = heads[head_idx];

  // memory read at accept
  assign in_ready = (state == S_IDLE);
  assign rd_en    = in_valid && in_ready;
  assign rd_addr  = (dec_op.kind == OP_FREE) ? dec_op.granule : head_rd[GRAN_W-1:0];

  // execute step
  assign exec_go = (state == S_EXEC) && (!out_valid || out_ready);
  assign span    = SPAN_W'(1) << op.cls;
  assign full    = (SPAN_W'(bump) + span) > SPAN_W'(ARENA_GRANULES);

  always_comb begin
    rsp_next     = '{user_address: '0, size_class: '0, status: ST_NULL};
    wr           = '{link_we: 1'b0, tag_we: 1'b0, addr: op.granule,
                     link: EMPTY_MARK, tag: op.cls[CI_W-1:0]};
    head_we      = 1'b0;
    head_wr_idx  = op.cls[CI_W-1:0];
    head_wr_val  = EMPTY_MARK;
    bump_next    = bump;
    carve        = 1'b0;
    case (op.kind)
      OP_BAD_SIZE: begin
        rsp_next.status = ST_BAD_SIZE;
      end
      OP_TOO_LARGE: begin
        rsp_next.status = ST_TOO_LARGE;
      end
      OP_ALLOC: begin
        rsp_next.size_class = CLASS_W'(op.cls);
        if (head < EMPTY_MARK) begin
          // pop the list head
          head_we      = 1'b1;
          head_wr_val  = (link_rd < EMPTY_MARK) ? link_rd : EMPTY_MARK;
          rsp_next.user_address = ADDR_W'({head[GRAN_W-1:0], OFFS_W'(HEADER_BYTES)});
          rsp_next.status       = ST_FROM_LIST;
        end else if (full) begin
          rsp_next.status = ST_ARENA_FULL;
        end else begin
          // carve a fresh block from the bump pointer
          carve      = 1'b1;
          wr.link_we = 1'b1;
          wr.tag_we  = 1'b1;
          wr.addr    = bump[GRAN_W-1:0];
          bump_next  = PTR_W'(SPAN_W'(bump) + span);
          rsp_next.user_address = ADDR_W'({bump[GRAN_W-1:0], OFFS_W'(HEADER_BYTES)});
          rsp_next.status       = ST_FROM_ARENA;
        end
      end
      OP_FREE: begin
        if (32'(tag_rd) < 32'(NUM_CLASSES)) begin
          // push onto the list of the stored class
          wr.link_we  = 1'b1;
          wr.link     = head_rd;
          head_we     = 1'b1;
          head_wr_idx = tag_rd;
          head_wr_val = PTR_W'(op.granule);
          rsp_next.size_class = CLASS_W'(tag_rd);
          rsp_next.status     = ST_FREED;
        end
      end
      default: begin
        rsp_next.status = ST_NULL;
      end
    endcase
    if (!exec_go) begin
      wr.link_we = 1'b0;
      wr.tag_we  = 1'b0;
    end
  end

  // control, list heads and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bump      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads[i] <= EMPTY_MARK;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (rd_en) begin
            state <= S_EXEC;
            op    <= dec_op;
            head  <= head_rd;
          end
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            out_rsp   <= rsp_next;
            bump      <= bump_next;
            if (head_we) begin
              heads[head_wr_idx] <= head_wr_val;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // bump pointer stays inside the arena
  a_bump_in_arena: assert property (@(posedge clk) disable iff (rst)
    bump <= EMPTY_MARK)
    else $error("bump pointer beyond arena");

  // bump pointer only moves when a block is carved
  a_bump_only_on_carve: assert property (@(posedge clk) disable iff (rst)
    !(exec_go && carve) |=> $stable(bump))
    else $error("bump pointer moved without a carve");

  // a carve advances the bump pointer by the block span
  a_bump_step: assert property (@(posedge clk) disable iff (rst)
    (exec_go && carve) |=> (bump == $past(bump_next)) && (bump != $past(bump)))
    else $error("carve did not advance bump pointer");

  // a result appears only out of the execute step
  a_out_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result without execute step");
`endif

endmodule
